>>> rtl/descending_exchange_sort_assert.svh
// Assertion macros shared by the descending exchange sort RTL.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef DESCENDING_EXCHANGE_SORT_ASSERT_SVH
`define DESCENDING_EXCHANGE_SORT_ASSERT_SVH

// Condition that must hold on every clock edge out of reset
`define DXS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define DXS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dxs_pkg.sv
// Package for the descending exchange sort: sizes, entry type, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package dxs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SCORE_W     = 24;
  localparam int TAG_W       = 8;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // One stored pair, score in the low bits
  typedef struct packed {
    tag_t   tag;
    score_t score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_LOAD,   // collecting entries
    S_I_RD,   // check outer bound, read entry i
    S_I_LD,   // latch entry i as current, read first j
    S_J,      // inner pass: compare/swap against j, stream reads
    S_I_WR,   // write current back to position i
    S_E_RD,   // read entry for emission
    S_E_LD    // load output register
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic in_wr;     // store an input entry
    logic cnt_clr;   // close the set
    logic i_clr;
    logic i_inc;
    logic j_set;     // j = i + 1
    logic rd_j;      // read at j, advance j, remember pending index
    logic cur_load;  // current = read data
    logic cmp_en;    // compare read data with current, swap on greater
    logic wr_i;      // write current to position i
    logic out_load;  // read data into output register
  } dxs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic i_last;    // i + 1 >= entry count
    logic j_end;     // j >= entry count
    logic out_free;  // output register empty
  } dxs_sts_t;

endpackage

>>> rtl/dxs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dxs_datapath.sv
// Datapath of the descending exchange sort: entry RAM, counters, current-entry
// register, comparator and output register. Depends on dxs_pkg and dxs_ram.
module dxs_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  dxs_pkg::dxs_cmd_t cmd,
  output dxs_pkg::dxs_sts_t sts,
  input  dxs_pkg::score_t   in_score,
  input  dxs_pkg::tag_t     in_tag,
  input  logic              out_tready,
  output logic              out_tvalid,
  output dxs_pkg::score_t   out_score,
  output dxs_pkg::tag_t     out_tag,
  output logic              out_last
);

`include "descending_exchange_sort_assert.svh"

  dxs_pkg::cnt_t   cnt_r, cnt_nxt;
  dxs_pkg::cnt_t   i_r, i_nxt;
  dxs_pkg::cnt_t   j_r, j_nxt;
  dxs_pkg::idx_t   pj_r, pj_nxt;
  dxs_pkg::entry_t cur_r, cur_nxt;
  dxs_pkg::entry_t out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_last_r, out_last_nxt;

  dxs_pkg::entry_t rdata;
  dxs_pkg::entry_t wdata;
  dxs_pkg::idx_t   waddr;
  dxs_pkg::idx_t   raddr;
  logic            we;
  logic            full;
  logic            swap;
  dxs_pkg::cnt_t   i_plus1;

  assign full    = (cnt_r == dxs_pkg::CNT_W'(dxs_pkg::MAX_ENTRIES));
  assign i_plus1 = i_r + dxs_pkg::CNT_W'(1);
  assign swap    = cmd.cmp_en && (cur_r.score < rdata.score);

  // Status back to the controller
  assign sts.i_last   = (i_plus1 >= cnt_r);
  assign sts.j_end    = (j_r >= cnt_r);
  assign sts.out_free = !out_valid_r;

  // RAM port muxing; write sources are exclusive by controller state
  always_comb begin
    raddr = cmd.rd_j ? j_r[dxs_pkg::IDX_W-1:0] : i_r[dxs_pkg::IDX_W-1:0];
    we    = 1'b0;
    waddr = i_r[dxs_pkg::IDX_W-1:0];
    wdata = cur_r;
    if (cmd.in_wr) begin
      we          = !full;
      waddr       = cnt_r[dxs_pkg::IDX_W-1:0];
      wdata.score = in_score;
      wdata.tag   = in_tag;
    end else if (swap) begin
      we    = 1'b1;
      waddr = pj_r;
    end else if (cmd.wr_i) begin
      we = 1'b1;
    end
  end

  dxs_ram #(
    .WIDTH(dxs_pkg::ENTRY_W),
    .DEPTH(dxs_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Counters and current entry
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.in_wr && !full) begin
      cnt_nxt = cnt_r + dxs_pkg::CNT_W'(1);
    end

    i_nxt = i_r;
    if (cmd.i_clr) begin
      i_nxt = '0;
    end else if (cmd.i_inc) begin
      i_nxt = i_plus1;
    end

    j_nxt  = j_r;
    pj_nxt = pj_r;
    if (cmd.j_set) begin
      j_nxt = i_plus1;
    end else if (cmd.rd_j) begin
      j_nxt  = j_r + dxs_pkg::CNT_W'(1);
      pj_nxt = j_r[dxs_pkg::IDX_W-1:0];
    end

    cur_nxt = (cmd.cur_load || swap) ? rdata : cur_r;
  end

  // Output register
  always_comb begin
    out_r_hold: begin
      out_nxt       = out_r;
      out_last_nxt  = out_last_r;
      out_valid_nxt = out_valid_r;
    end
    if (cmd.out_load) begin
      out_nxt       = rdata;
      out_last_nxt  = sts.i_last;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pj_r       <= pj_nxt;
    cur_r      <= cur_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_score  = out_r.score;
  assign out_tag    = out_r.tag;
  assign out_last   = out_last_r;

  `DXS_ASSERT_ALWAYS(a_cnt_range, cnt_r <= dxs_pkg::CNT_W'(dxs_pkg::MAX_ENTRIES), "entry count overflow")
  `DXS_ASSERT_ALWAYS(a_out_no_overwrite, !cmd.out_load || !out_valid_r, "output register overwritten")
  `DXS_ASSERT_ALWAYS(a_swap_after_i, !swap || (dxs_pkg::CNT_W'(pj_r) > i_r), "swap target not after i")

endmodule

>>> rtl/dxs_ctrl.sv
// Controller FSM of the descending exchange sort: load, outer/inner sort
// passes and emission. Depends on dxs_pkg.
module dxs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  dxs_pkg::dxs_sts_t sts,
  output dxs_pkg::dxs_cmd_t cmd
);

`include "descending_exchange_sort_assert.svh"

  dxs_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dxs_pkg::S_LOAD: begin
        if (in_tvalid && in_tlast) state_nxt = dxs_pkg::S_I_RD;
      end
      dxs_pkg::S_I_RD: begin
        state_nxt = sts.i_last ? dxs_pkg::S_E_RD : dxs_pkg::S_I_LD;
      end
      dxs_pkg::S_I_LD: state_nxt = dxs_pkg::S_J;
      dxs_pkg::S_J: begin
        if (sts.j_end) state_nxt = dxs_pkg::S_I_WR;
      end
      dxs_pkg::S_I_WR: state_nxt = dxs_pkg::S_I_RD;
      dxs_pkg::S_E_RD: begin
        if (sts.out_free) state_nxt = dxs_pkg::S_E_LD;
      end
      dxs_pkg::S_E_LD: begin
        state_nxt = sts.i_last ? dxs_pkg::S_LOAD : dxs_pkg::S_E_RD;
      end
      default: state_nxt = dxs_pkg::S_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dxs_pkg::S_LOAD: begin
        in_tready = 1'b1;
        cmd.in_wr = in_tvalid;
        cmd.i_clr = in_tvalid && in_tlast;
      end
      dxs_pkg::S_I_RD: begin
        cmd.i_clr = sts.i_last;
        cmd.j_set = !sts.i_last;
      end
      dxs_pkg::S_I_LD: begin
        cmd.cur_load = 1'b1;
        cmd.rd_j     = 1'b1;
      end
      dxs_pkg::S_J: begin
        cmd.cmp_en = 1'b1;
        cmd.rd_j   = !sts.j_end;
      end
      dxs_pkg::S_I_WR: begin
        cmd.wr_i  = 1'b1;
        cmd.i_inc = 1'b1;
      end
      dxs_pkg::S_E_RD: begin
        cmd = '0;
      end
      dxs_pkg::S_E_LD: begin
        cmd.out_load = 1'b1;
        cmd.i_inc    = 1'b1;
        cmd.cnt_clr  = sts.i_last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dxs_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  `DXS_ASSERT_NEXT(a_last_emit_returns, (state_r == dxs_pkg::S_E_LD) && sts.i_last, state_r == dxs_pkg::S_LOAD, "set did not close after last result")
  `DXS_ASSERT_NEXT(a_inner_ends, (state_r == dxs_pkg::S_J) && sts.j_end, state_r == dxs_pkg::S_I_WR, "inner pass did not end")

endmodule

>>> rtl/descending_exchange_sort.sv
// Descending exchange sort of up to 64 (score, tag) pairs. Load: one item per cycle while
// in the load state; in_tready is low while sorting and emitting. Sort: one compare per
// cycle in the inner pass, through the single write and single read port of the entry RAM.
// Emission: a result is loaded into the output register only once the previous one is taken.
// The output register lets the next set load while the final result waits.
// Reset (rst_n low, synchronous) empties the set and output register; RAM is not cleared.
module descending_exchange_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [23:0] score, [31:24] tag
  input  logic        in_tlast,   // last_entry
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [23:0] sorted_score, [31:24] sorted_tag
  output logic        out_tlast   // last_result
);

  dxs_pkg::dxs_cmd_t cmd;
  dxs_pkg::dxs_sts_t sts;
  dxs_pkg::score_t   out_score;
  dxs_pkg::tag_t     out_tag;

  dxs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tlast (in_tlast),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dxs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_score  (in_tdata[23:0]),
    .in_tag    (in_tdata[31:24]),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_score (out_score),
    .out_tag   (out_tag),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_tag, out_score};

endmodule
